>>> sv/oil_pkg.sv
// shared types and constants for the ordered id list
// no dependencies; used by oil_ram, oil_ctrl and ordered_id_list
package oil_pkg;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned ID_W  = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ID_W-1:0]  id_t;

    localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LIST   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_LIST,
        S_RESP
    } state_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        id_t  wdata;
        idx_t raddr;
    } ram_req_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        id_t     ident;
        logic    last;
    } res_t;

endpackage

>>> sv/oil_ram.sv
// entry store: one write port, one read port, registered read data
// depends on oil_pkg
module oil_ram (
    input  logic               clk,
    input  oil_pkg::ram_req_t  req,
    output oil_pkg::id_t       rdata
);

    oil_pkg::id_t mem [oil_pkg::DEPTH];
    oil_pkg::id_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/oil_ctrl.sv
// sequencer: append, search and shift for remove, list walk, clear
// depends on oil_pkg; drives the oil_ram port
module oil_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  oil_pkg::id_t       ident,
    output oil_pkg::ram_req_t  ram_req,
    input  oil_pkg::id_t       rdata,
    output oil_pkg::res_t      res,
    input  logic               res_take
);

    oil_pkg::state_t  state_reg, state_next;
    oil_pkg::cnt_t    cnt_reg, cnt_next;
    oil_pkg::idx_t    ptr_reg, ptr_next;
    oil_pkg::id_t     key_reg, key_next;
    oil_pkg::status_t rstat_reg, rstat_next;

    oil_pkg::cnt_t ptr1;
    oil_pkg::cnt_t ptr2;

    assign ptr1 = oil_pkg::cnt_t'(ptr_reg) + oil_pkg::cnt_t'(1);
    assign ptr2 = oil_pkg::cnt_t'(ptr_reg) + oil_pkg::cnt_t'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oil_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        key_reg   <= key_next;
        rstat_reg <= rstat_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        key_next      = key_reg;
        rstat_next    = rstat_reg;
        ram_req       = '0;
        ram_req.raddr = ptr_reg;
        res           = '0;
        res.status    = oil_pkg::ST_OK;
        in_stall      = (state_reg != oil_pkg::S_IDLE);

        case (state_reg)
            oil_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (oil_pkg::kind_t'(kind))
                        oil_pkg::KIND_APPEND:
                        begin
                            if (cnt_reg == oil_pkg::DEPTH_CNT)
                            begin
                                rstat_next = oil_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = cnt_reg[oil_pkg::IDX_W-1:0];
                                ram_req.wdata = ident;
                                cnt_next      = cnt_reg + oil_pkg::cnt_t'(1);
                                rstat_next    = oil_pkg::ST_OK;
                            end
                            state_next = oil_pkg::S_RESP;
                        end
                        oil_pkg::KIND_REMOVE:
                        begin
                            key_next      = ident;
                            ptr_next      = '0;
                            ram_req.raddr = '0;
                            if (cnt_reg == '0)
                            begin
                                rstat_next = oil_pkg::ST_NOTFOUND;
                                state_next = oil_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = oil_pkg::S_SEARCH;
                            end
                        end
                        oil_pkg::KIND_LIST:
                        begin
                            ptr_next      = '0;
                            ram_req.raddr = '0;
                            if (cnt_reg == '0)
                            begin
                                rstat_next = oil_pkg::ST_EMPTY;
                                state_next = oil_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = oil_pkg::S_LIST;
                            end
                        end
                        oil_pkg::KIND_CLEAR:
                        begin
                            cnt_next   = '0;
                            rstat_next = oil_pkg::ST_OK;
                            state_next = oil_pkg::S_RESP;
                        end
                        default:
                        begin
                            state_next = oil_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // rdata holds entry ptr_reg
            oil_pkg::S_SEARCH:
            begin
                if (rdata == key_reg)
                begin
                    if (ptr1 == cnt_reg)
                    begin
                        cnt_next   = cnt_reg - oil_pkg::cnt_t'(1);
                        rstat_next = oil_pkg::ST_OK;
                        state_next = oil_pkg::S_RESP;
                    end
                    else
                    begin
                        ram_req.raddr = ptr1[oil_pkg::IDX_W-1:0];
                        state_next    = oil_pkg::S_SHIFT;
                    end
                end
                else if (ptr1 == cnt_reg)
                begin
                    rstat_next = oil_pkg::ST_NOTFOUND;
                    state_next = oil_pkg::S_RESP;
                end
                else
                begin
                    ptr_next      = ptr1[oil_pkg::IDX_W-1:0];
                    ram_req.raddr = ptr1[oil_pkg::IDX_W-1:0];
                end
            end

            // rdata holds entry ptr_reg+1, moved down one place
            oil_pkg::S_SHIFT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                ram_req.wdata = rdata;
                if (ptr2 == cnt_reg)
                begin
                    cnt_next   = cnt_reg - oil_pkg::cnt_t'(1);
                    rstat_next = oil_pkg::ST_OK;
                    state_next = oil_pkg::S_RESP;
                end
                else
                begin
                    ptr_next      = ptr1[oil_pkg::IDX_W-1:0];
                    ram_req.raddr = ptr2[oil_pkg::IDX_W-1:0];
                end
            end

            // re-read the same entry while the output holds
            oil_pkg::S_LIST:
            begin
                res.valid  = 1'b1;
                res.status = oil_pkg::ST_OK;
                res.ident  = rdata;
                res.last   = (ptr1 == cnt_reg);
                if (res_take)
                begin
                    if (ptr1 == cnt_reg)
                    begin
                        state_next = oil_pkg::S_IDLE;
                    end
                    else
                    begin
                        ptr_next      = ptr1[oil_pkg::IDX_W-1:0];
                        ram_req.raddr = ptr1[oil_pkg::IDX_W-1:0];
                    end
                end
            end

            oil_pkg::S_RESP:
            begin
                res.valid  = 1'b1;
                res.status = rstat_reg;
                res.last   = 1'b1;
                if (res_take)
                begin
                    state_next = oil_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = oil_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/ordered_id_list.sv
// top level of the ordered id list: sequencer, entry store, output register
// depends on oil_pkg, oil_ram, oil_ctrl
//
//  channel | signals                    | direction
//  --------+----------------------------+----------
//  in      | in_valid in_stall kind ident | request in
//  out     | out_valid out_stall status listed_ident last | result out
//
// append and clear give a result; remove searches entries in order, moves
// later entries down (each entry is searched or shifted, one store read
// apiece); list reads entries in order, all through the single read port
// of the entry store. out_stall keeps a held result in the output register
// and holds list/result states. reset clears occupancy, state, out_valid only
module ordered_id_list (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   kind,
    input  logic [31:0]  ident,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   status,
    output logic [31:0]  listed_ident,
    output logic         last
);

    oil_pkg::ram_req_t ram_req;
    oil_pkg::id_t      rdata;
    oil_pkg::res_t     res;

    logic         out_free;
    logic         out_valid_reg, out_valid_next;
    logic [1:0]   status_reg;
    logic [31:0]  ident_reg;
    logic         last_reg;

    assign out_free = !out_valid_reg || !out_stall;

    oil_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    oil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .ident    (ident),
        .ram_req  (ram_req),
        .rdata    (rdata),
        .res      (res),
        .res_take (out_free)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            status_reg <= res.status;
            ident_reg  <= res.ident;
            last_reg   <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign listed_ident = ident_reg;
    assign last         = last_reg;

endmodule
